>>> hw/rtl/swm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants of the sliding window median filter.
// ----------------------------------------------------------------------------
package swm_pkg;

  // configuration port
  localparam int CFG_DATA_W = 6;   // widest register (window_size)
  localparam int WSIZE_W    = 6;

  typedef enum logic [0:0] {
    REG_WINDOW_SIZE = 1'b0,
    REG_MEDIAN_MODE = 1'b1
  } cfg_reg_t;

  // broadcast control to every cell
  typedef struct packed {
    logic step;   // update cells this cycle
    logic ins;    // insert the sample (0: delete only)
    logic clr;    // restart: treat every cell as empty
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/swm_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm_cell
// One slot of the sorted window: value, age, valid; shifts with its neighbors.
// ----------------------------------------------------------------------------
module swm_cell
  import swm_pkg::*;
#(
  parameter int SB = 16,
  parameter int AW = 5
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire cell_ctl_t            ctl,
  input  wire logic signed [SB-1:0] smp,
  input  wire logic [AW-1:0]        del_age,
  // left neighbor (lower index, smaller values)
  input  wire logic signed [SB-1:0] l_val,
  input  wire logic [AW-1:0]        l_age,
  input  wire logic                 l_vld,
  input  wire logic                 l_g,
  input  wire logic                 l_d,
  // right neighbor
  input  wire logic signed [SB-1:0] r_val,
  input  wire logic [AW-1:0]        r_age,
  input  wire logic                 r_vld,
  input  wire logic                 r_g,
  // own state toward neighbors
  output logic signed [SB-1:0]      o_val,
  output logic [AW-1:0]             o_age,
  output logic                      o_vld,
  output logic                      o_g,
  output logic                      o_d
);

  logic signed [SB-1:0] value, value_next;
  logic [AW-1:0]        age, age_next;
  logic                 valid, valid_next;

  logic vld_e, gt, del, d_here, rg_here, rg_left;
  logic [AW-1:0] inc;

  assign vld_e  = valid & ~ctl.clr;
  // g: this slot lies past the insertion point (empty or larger)
  assign gt     = ~vld_e | (value > smp);
  assign del    = vld_e & (age == del_age);
  // d: a deletion at this slot or to its left
  assign d_here = l_d | del;
  // g after the deletion has closed the gap
  assign rg_here = d_here ? r_g : gt;
  assign rg_left = l_d ? gt : l_g;
  assign inc     = ctl.ins ? AW'(1) : '0;

  always_comb begin
    value_next = value;
    age_next   = age;
    valid_next = valid;
    if (ctl.step) begin
      if (!ctl.ins || !rg_here) begin
        if (d_here) begin
          value_next = r_val;
          age_next   = r_age + inc;
          valid_next = r_vld;
        end else begin
          age_next   = age + inc;
          valid_next = vld_e;
        end
      end else if (!rg_left) begin
        value_next = smp;
        age_next   = '0;
        valid_next = 1'b1;
      end else if (l_d) begin
        age_next   = age + 1'b1;
        valid_next = vld_e;
      end else begin
        value_next = l_val;
        age_next   = l_age + 1'b1;
        valid_next = l_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    age   <= age_next;
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  assign o_val = value;
  assign o_age = age;
  assign o_vld = vld_e;
  assign o_g   = gt;
  assign o_d   = d_here;

endmodule

`default_nettype wire

>>> hw/rtl/swm_median.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swm_median
// Picks the middle cell(s) of the sorted row and forms twice the median.
// ----------------------------------------------------------------------------
module swm_median #(
  parameter int WM = 32,
  parameter int SB = 16,
  parameter int AW = 5,
  parameter int WW = 6
) (
  input  wire logic                 clk,
  input  wire logic [WW-1:0]        w_eff,
  input  wire logic                 mode,
  input  wire logic signed [SB-1:0] vals [WM],
  input  wire logic                 load,
  output logic signed [SB:0]        med
);

  logic [WM-1:0] tap_lo, tap_hi;
  logic [AW-1:0] lo_idx, hi_idx;
  logic [SB-1:0] a, b;

  // taps follow the window size and median mode registers
  always_comb begin
    lo_idx = AW'((w_eff - 1'b1) >> 1);
    hi_idx = AW'(w_eff >> 1);
    if (mode && !w_eff[0]) begin
      hi_idx = lo_idx;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < WM; i++) begin
      tap_lo[i] <= (lo_idx == AW'(i));
      tap_hi[i] <= (hi_idx == AW'(i));
    end
  end

  always_comb begin
    a = '0;
    b = '0;
    for (int i = 0; i < WM; i++) begin
      a = a | (vals[i] & {SB{tap_lo[i]}});
      b = b | (vals[i] & {SB{tap_hi[i]}});
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      med <= $signed({a[SB-1], a}) + $signed({b[SB-1], b});
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/sliding_window_median.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_median
// Running median over the last window_size samples, kept in a sorted cell row.
// ----------------------------------------------------------------------------
// The block keeps the window in a row of WINDOW_MAX cells sorted by value.
// Each accepted sample is inserted at its sorted place in the same cycle as
// the oldest sample leaves, every cell taking its next content from itself,
// a neighbor or the new sample. One sample is taken per clock unless the row
// is shrinking or held for a full output register; the median of the updated
// row is then read into the output register once it is free. Results start
// once window_size samples have arrived since reset or a restart (tuser high
// on the sample). Output is twice the median (one fraction bit): for an even
// window the sum of both middles, or twice the lower middle when median_mode
// is 1. A window_size of 0 acts as 1, sizes above WINDOW_MAX saturate.
// Shrinking the window drops the excess oldest samples one per cycle, unless
// held for a full output register, before the next sample is taken; growing
// it withholds results until the window has filled again.
// ----------------------------------------------------------------------------
module sliding_window_median
  import swm_pkg::*;
#(
  parameter  int WINDOW_MAX  = 32,
  parameter  int SAMPLE_BITS = 16,
  localparam int IN_W  = ((SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((SAMPLE_BITS + 8) / 8) * 8
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration writes
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // sample stream
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_W-1:0]       s_tdata,   // [SAMPLE_BITS-1:0] sample
  input  wire logic                  s_tuser,   // restart
  // result stream
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_W-1:0]           m_tdata    // [SAMPLE_BITS:0] median_twice
);

  localparam int SB = SAMPLE_BITS;
  localparam int WM = WINDOW_MAX;
  localparam int AW = (WM > 1) ? $clog2(WM) : 1;
  localparam int WW = $clog2(WM + 1);

  // registers
  logic [WSIZE_W-1:0] wsz;
  logic               mode;
  logic [WW-1:0]      fill, fill_next;
  logic               pend, pend_next;
  logic               ov, ov_next;

  logic [WW-1:0]        w_eff;
  logic                 shrink, stuck, pend_adv, in_xfer, item_res;
  logic [AW-1:0]        del_age;
  cell_ctl_t            ctl;
  logic signed [SB-1:0] smp;
  logic signed [SB:0]   med;

  // cell row taps
  logic signed [SB-1:0] c_val [WM];
  logic [AW-1:0]        c_age [WM];
  logic [WM-1:0]        c_vld, c_g, c_d;

  assign smp = s_tdata[SB-1:0];

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      wsz  <= WSIZE_W'(3);
      mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WINDOW_SIZE: wsz  <= cfg_data[WSIZE_W-1:0];
        REG_MEDIAN_MODE: mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (wsz == '0) begin
      w_eff = WW'(1);
    end else if (32'(wsz) > WM) begin
      w_eff = WW'(WM);
    end else begin
      w_eff = WW'(wsz);
    end
  end

  // handshake: the median stage reads the row once the transfer's pending
  // result advances, so the row holds while a full output register blocks it
  assign shrink   = fill > w_eff;
  assign stuck    = pend & ov & ~m_tready;
  assign pend_adv = pend & (~ov | m_tready);
  assign s_tready = ~shrink & ~stuck;
  assign in_xfer  = s_tvalid & s_tready;

  always_comb begin
    ctl.step  = in_xfer | (shrink & ~stuck);
    ctl.ins   = in_xfer;
    ctl.clr   = in_xfer & s_tuser;
    // insert: oldest leaves when it reaches the window; shrink: drop oldest
    del_age   = shrink ? AW'(fill - 1'b1) : AW'(w_eff - 1'b1);
    fill_next = fill;
    item_res  = 1'b0;
    if (in_xfer) begin
      if (s_tuser) begin
        fill_next = WW'(1);
      end else if (fill != w_eff) begin
        fill_next = fill + 1'b1;
      end
      item_res = (fill_next == w_eff);
    end else if (shrink && !stuck) begin
      fill_next = fill - 1'b1;
    end
    pend_next = item_res | (pend & ~pend_adv);
    ov_next   = pend_adv | (ov & ~m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      pend <= 1'b0;
      ov   <= 1'b0;
    end else begin
      fill <= fill_next;
      pend <= pend_next;
      ov   <= ov_next;
    end
  end

  // sorted cell row, smallest at index 0
  for (genvar i = 0; i < WM; i++) begin : g_cell
    logic signed [SB-1:0] lv, rv;
    logic [AW-1:0]        la, ra;
    logic                 lvl, rvl, lg, rg, ld;

    if (i == 0) begin : g_first
      assign lv  = '0;
      assign la  = '0;
      assign lvl = 1'b0;
      assign lg  = 1'b0;
      assign ld  = 1'b0;
    end else begin : g_mid_l
      assign lv  = c_val[i-1];
      assign la  = c_age[i-1];
      assign lvl = c_vld[i-1];
      assign lg  = c_g[i-1];
      assign ld  = c_d[i-1];
    end

    if (i == WM - 1) begin : g_last
      assign rv  = '0;
      assign ra  = '0;
      assign rvl = 1'b0;
      assign rg  = 1'b1;
    end else begin : g_mid_r
      assign rv  = c_val[i+1];
      assign ra  = c_age[i+1];
      assign rvl = c_vld[i+1];
      assign rg  = c_g[i+1];
    end

    swm_cell #(
      .SB (SB),
      .AW (AW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .smp     (smp),
      .del_age (del_age),
      .l_val   (lv),
      .l_age   (la),
      .l_vld   (lvl),
      .l_g     (lg),
      .l_d     (ld),
      .r_val   (rv),
      .r_age   (ra),
      .r_vld   (rvl),
      .r_g     (rg),
      .o_val   (c_val[i]),
      .o_age   (c_age[i]),
      .o_vld   (c_vld[i]),
      .o_g     (c_g[i]),
      .o_d     (c_d[i])
    );
  end

  // median pick and output register
  swm_median #(
    .WM (WM),
    .SB (SB),
    .AW (AW),
    .WW (WW)
  ) u_median (
    .clk   (clk),
    .w_eff (w_eff),
    .mode  (mode),
    .vals  (c_val),
    .load  (pend_adv),
    .med   (med)
  );

  assign m_tvalid = ov;
  assign m_tdata  = OUT_W'($unsigned(med));

endmodule

`default_nettype wire
